FILE: rtl/key_hold_time_classifier_assert.svh
// ----------------------------------------------------------------------------
// Key hold time classifier assertion macros
// Shared property forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_HOLD_TIME_CLASSIFIER_ASSERT_SVH
`define KEY_HOLD_TIME_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define KHT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/kht_pkg.sv
// ----------------------------------------------------------------------------
// kht_pkg
// Types, constants and codes shared by the key hold time classifier.
// ----------------------------------------------------------------------------
package kht_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int KEY_W       = 16;
   localparam int THR_W       = 48;
   localparam int HANDLE_W    = 32;
   localparam int ENTRY_W     = KEY_W + THR_W + HANDLE_W;
   localparam int SEC_W       = 32;
   localparam int USEC_W      = 20;
   localparam int STAMP_W     = SEC_W + USEC_W;

   localparam logic signed [USEC_W:0] US_PER_SEC = 21'sd1000000;
   localparam logic [THR_W-1:0]       HOLD_MAX   = 48'hFFFF_FFFF_FFFF;

   // opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // event type and value codes
   localparam logic [15:0]        EV_KEY    = 16'd1;
   localparam logic signed [31:0] VAL_PRESS = 32'sd1;

   // status codes
   localparam logic [1:0] ST_NONE   = 2'd0;
   localparam logic [1:0] ST_FIRED  = 2'd1;
   localparam logic [1:0] ST_LOADED = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic                       opcode;
      logic [15:0]                event_type;
      logic [15:0]                event_code;
      logic signed [31:0]         event_value;
      logic [SEC_W-1:0]           time_sec;
      logic [USEC_W-1:0]          time_usec;
      logic [KEY_W-1:0]           entry_key;
      logic [THR_W-1:0]           entry_threshold_us;
      logic signed [HANDLE_W-1:0] entry_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic                       button;
      logic [THR_W-1:0]           hold_us;
      logic signed [HANDLE_W-1:0] fired_handle;
   } rsp_type;

   typedef struct packed {
      logic             neg;
      logic [THR_W-1:0] hold;
   } hold_res_type;

endpackage

FILE: rtl/kht_ram.sv
// ----------------------------------------------------------------------------
// kht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/kht_hold.sv
// ----------------------------------------------------------------------------
// kht_hold
// Hold time unit: registered seconds product, then microsecond add,
// sign check and saturation.
// ----------------------------------------------------------------------------
module kht_hold (
   input  logic                             clock,
   input  logic [kht_pkg::SEC_W-1:0]        rel_sec,
   input  logic [kht_pkg::USEC_W-1:0]       rel_usec,
   input  logic [kht_pkg::SEC_W-1:0]        prs_sec,
   input  logic [kht_pkg::USEC_W-1:0]       prs_usec,
   output kht_pkg::hold_res_type            res
);

   logic signed [kht_pkg::SEC_W:0]  dsec;
   logic signed [kht_pkg::USEC_W:0] dus_in;
   logic signed [53:0]              prod_in;
   logic signed [53:0]              prod_ff;
   logic signed [kht_pkg::USEC_W:0] dus_ff;
   logic signed [54:0]              sum;

   assign dsec    = $signed({1'b0, rel_sec}) - $signed({1'b0, prs_sec});
   assign dus_in  = $signed({1'b0, rel_usec}) - $signed({1'b0, prs_usec});
   assign prod_in = 54'(dsec) * 54'(kht_pkg::US_PER_SEC);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      dus_ff  <= dus_in;
   end

   assign sum = 55'(prod_ff) + 55'(dus_ff);

   // negative hold reports zero; above 48 bits saturate
   always_comb begin
      res.neg = sum[54];
      if (sum[54]) begin
         res.hold = '0;
      end else if (|sum[53:48]) begin
         res.hold = kht_pkg::HOLD_MAX;
      end else begin
         res.hold = sum[47:0];
      end
   end

endmodule

FILE: rtl/key_hold_time_classifier.sv
// ----------------------------------------------------------------------------
// key_hold_time_classifier
// Long-press classifier: entry table in RAM, press stamps in RAM, scan
// sequencer picking the best entry on each button release.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_payload, taken at a clock edge with start high and
//   busy low. A load request appends (key, threshold, handle) to the entry
//   table; an event request handles one input event for the two buttons at
//   csr_data and csr_data+1 as set through the csr_ write channel (reset 105).
//   Every request yields exactly one response: rsp_valid is high for one
//   cycle with rsp_payload, and the receiver cannot hold it off.
// Timing:
//   Loads, presses and ignored events respond the cycle after acceptance
//   and leave busy low, so one such request may enter every cycle unless a
//   release holds busy. A release reads the press stamp RAM, forms the
//   product in the hold unit, adds and saturates, then scans the entry RAM
//   one entry per cycle and closes in S_DONE; a negative hold or an empty
//   table answers without a scan. The table read port paces the scan.
// Reset:
//   Clears entry count, press stamps (valid bits read as zero), the response
//   strobe; sets button code to 105. Table contents need no clearing.
// ----------------------------------------------------------------------------
`include "key_hold_time_classifier_assert.svh"

module key_hold_time_classifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kht_pkg::req_type req_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data,
   output logic             rsp_valid,
   output kht_pkg::rsp_type rsp_payload
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIFF = 5'b00010,
      S_SUM  = 5'b00100,
      S_SCAN = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   localparam int IDX_W = kht_pkg::IDX_W;
   localparam int CNT_W = kht_pkg::CNT_W;

   state_type state_ff, state_in;

   // control state
   logic [15:0]      key_code_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       prs_vld_ff, prs_vld_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;

   // payload
   kht_pkg::req_type              req_ff, req_in;
   kht_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          btn_ff, btn_in;
   logic [kht_pkg::THR_W-1:0]     hold_ff, hold_in;
   logic [kht_pkg::THR_W-1:0]     best_thr_ff, best_thr_in;
   logic [kht_pkg::HANDLE_W-1:0]  best_handle_ff, best_handle_in;

   // decode of the incoming request
   logic accept;
   logic is_key, hit0, hit1, is_press;

   // RAM ports
   logic                          prs_we;
   logic [kht_pkg::STAMP_W-1:0]   prs_rdata;
   logic [kht_pkg::STAMP_W-1:0]   prs_stamp;
   logic                          tbl_we;
   logic [IDX_W-1:0]              tbl_raddr;
   logic [kht_pkg::ENTRY_W-1:0]   tbl_wdata, tbl_rdata;

   // scan compare
   logic [kht_pkg::KEY_W-1:0]     ent_key;
   logic [kht_pkg::THR_W-1:0]     ent_thr;
   logic [kht_pkg::HANDLE_W-1:0]  ent_handle;
   logic                          ent_match;
   logic                          scan_last;

   kht_pkg::hold_res_type         hold_res;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign is_key   = (req_payload.opcode == kht_pkg::OP_EVENT) &&
                     (req_payload.event_type == kht_pkg::EV_KEY);
   assign hit0     = is_key && (req_payload.event_code == key_code_ff);
   // button 1 code compared in 17 bits so it never wraps onto code 0
   assign hit1     = is_key && ({1'b0, req_payload.event_code} ==
                                ({1'b0, key_code_ff} + 17'd1));
   assign is_press = (req_payload.event_value == kht_pkg::VAL_PRESS);

   // press stamp memory: one entry per button, valid bits stand in for reset
   assign prs_we = accept && (hit0 || hit1) && is_press;

   kht_ram #(
      .WIDTH (kht_pkg::STAMP_W),
      .DEPTH (2)
   ) u_press_ram (
      .clock (clock),
      .we    (prs_we),
      .waddr (hit1),
      .wdata ({req_payload.time_sec, req_payload.time_usec}),
      .raddr (hit1),
      .rdata (prs_rdata)
   );

   assign prs_stamp = rd_vld_ff ? prs_rdata : '0;

   kht_hold u_hold (
      .clock    (clock),
      .rel_sec  (req_ff.time_sec),
      .rel_usec (req_ff.time_usec),
      .prs_sec  (prs_stamp[kht_pkg::STAMP_W-1:kht_pkg::USEC_W]),
      .prs_usec (prs_stamp[kht_pkg::USEC_W-1:0]),
      .res      (hold_res)
   );

   // entry table: appended at the fill count, scanned from entry zero
   assign tbl_we    = accept && (req_payload.opcode == kht_pkg::OP_LOAD) &&
                      (count_ff < CNT_W'(kht_pkg::MAX_ENTRIES));
   assign tbl_wdata = {req_payload.entry_key, req_payload.entry_threshold_us,
                       req_payload.entry_handle};
   assign tbl_raddr = (state_ff == S_SCAN) ? scan_idx_ff + IDX_W'(1) : '0;

   kht_ram #(
      .WIDTH (kht_pkg::ENTRY_W),
      .DEPTH (kht_pkg::MAX_ENTRIES)
   ) u_table_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   assign ent_key    = tbl_rdata[kht_pkg::ENTRY_W-1 -: kht_pkg::KEY_W];
   assign ent_thr    = tbl_rdata[kht_pkg::HANDLE_W +: kht_pkg::THR_W];
   assign ent_handle = tbl_rdata[kht_pkg::HANDLE_W-1:0];

   // strict greater keeps the earliest entry on equal thresholds
   assign ent_match  = (ent_key == req_ff.event_code) && (ent_thr <= hold_ff) &&
                       (!found_ff || (ent_thr > best_thr_ff));
   assign scan_last  = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      prs_vld_in     = prs_vld_ff;
      rd_vld_in      = rd_vld_ff;
      rsp_valid_in   = 1'b0;
      found_in       = found_ff;
      scan_idx_in    = scan_idx_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      btn_in         = btn_ff;
      hold_in        = hold_ff;
      best_thr_in    = best_thr_ff;
      best_handle_in = best_handle_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in       = req_payload;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (req_payload.opcode == kht_pkg::OP_LOAD) begin
                  if (tbl_we) begin
                     count_in      = count_ff + CNT_W'(1);
                     rsp_in.status = kht_pkg::ST_LOADED;
                  end else begin
                     rsp_in.status = kht_pkg::ST_FULL;
                  end
               end else if ((hit0 || hit1) && is_press) begin
                  prs_vld_in[hit1] = 1'b1;
               end else if (hit0 || hit1) begin
                  // release: hold the response until the hold check or the scan closes
                  rsp_valid_in = 1'b0;
                  btn_in       = hit1;
                  rd_vld_in    = prs_vld_ff[hit1];
                  state_in     = S_DIFF;
               end
            end
         end
         S_DIFF: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            hold_in     = hold_res.hold;
            found_in    = 1'b0;
            scan_idx_in = '0;
            if (hold_res.neg || (count_ff == '0)) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = kht_pkg::ST_NONE;
               rsp_in.button       = btn_ff;
               rsp_in.hold_us      = hold_res.hold;
               rsp_in.fired_handle = '0;
               state_in            = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (ent_match) begin
               found_in       = 1'b1;
               best_thr_in    = ent_thr;
               best_handle_in = ent_handle;
            end
            if (scan_last) begin
               state_in = S_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = found_ff ? kht_pkg::ST_FIRED : kht_pkg::ST_NONE;
            rsp_in.button       = btn_ff;
            rsp_in.hold_us      = hold_ff;
            rsp_in.fired_handle = found_ff ? best_handle_ff : '0;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_code_ff  <= 16'd105;
         count_ff     <= '0;
         prs_vld_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         prs_vld_ff   <= prs_vld_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         scan_idx_ff  <= scan_idx_in;
         if (csr_valid && csr_ready) begin
            key_code_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      rsp_ff         <= rsp_in;
      btn_ff         <= btn_in;
      hold_ff        <= hold_in;
      best_thr_ff    <= best_thr_in;
      best_handle_ff <= best_handle_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `KHT_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(kht_pkg::MAX_ENTRIES), "entry count past table size")
   `KHT_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy, "accepted request neither answered nor in progress")
   `KHT_ASSERT_IMPL(a_full_reject, clock, reset, rsp_valid && (rsp_payload.status == kht_pkg::ST_FULL), count_ff == CNT_W'(kht_pkg::MAX_ENTRIES), "load rejected with room in table")
   `KHT_ASSERT_IMPL(a_scan_range, clock, reset, state_ff == S_SCAN, CNT_W'(scan_idx_ff) < count_ff, "scan index beyond loaded entries")

endmodule
